// File: sv/msnt_pkg.sv
// Shared types and constants for the music sequence note tracker.
// Command codes, channel numbering and the note record layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msnt_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_W       = 2;
    localparam int NOTE_ACC_W = 24;
    localparam int ROW_W      = 10;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // high nibble of a command byte
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_SAMPLE   = 4'hA;
    localparam logic [3:0] CMD_INSTR    = 4'hC;
    localparam logic [3:0] CMD_END_E    = 4'hE;
    localparam logic [3:0] CMD_END_F    = 4'hF;

    localparam logic [7:0] CMD_NONE      = 8'h00;
    localparam logic [7:0] VERSION_SHORT = 8'd1;
    localparam logic [7:0] VERSION_RESET = 8'd1;
    localparam logic [3:0] ROW_TICKS     = 4'd5;

    localparam logic [CH_W-1:0] CHAN_WAVE = 2'd2;

    // register index decoded from paddr[2]
    localparam logic REG_FORMAT_VERSION = 1'b0;

    typedef struct packed {
        logic                  has_note;
        logic [CH_W-1:0]       channel;
        logic [7:0]            pitch;
        logic [NOTE_ACC_W-1:0] duration;
        logic [NOTE_ACC_W-1:0] lead_gap;
        logic [7:0]            instrument;
        logic                  first;
        logic                  song_end;
    } note_rec_t;

endpackage

`default_nettype wire

// File: sv/music_sequence_note_tracker_core.sv
// Sequence byte framer and four-channel note tracker, top level.
// The result passes through the input register and then the result register.
// Throughput: one sequence byte per cycle; a result held by m_ready low stalls every byte.
// Reset (aresetn, synchronous): channels silent, accumulators and instruments zero,
// first marks set, no command pending, format_version = 1. Pitch storage is not reset.
// Depends on msnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module music_sequence_note_tracker_core
    import msnt_pkg::*;
#(
    parameter int ACC_BITS = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready,
    // sequence bytes
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_seq_byte,
    // note records
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_has_note,
    output logic [CH_W-1:0]            m_note_channel,
    output logic [7:0]                 m_note_pitch,
    output logic [NOTE_ACC_W-1:0]      m_note_duration,
    output logic [NOTE_ACC_W-1:0]      m_lead_gap,
    output logic [7:0]                 m_note_instrument,
    output logic                       m_first_after_change,
    output logic                       m_song_end
);

    localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

    // configuration
    logic [7:0] version_reg;
    logic       cfg_write;

    // input stage
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       advance;

    // channel state
    logic [CHANNELS-1:0] sounding_reg, sounding_next;
    logic [CHANNELS-1:0] first_reg, first_next;
    logic [ACC_BITS-1:0] len_reg  [CHANNELS];
    logic [ACC_BITS-1:0] len_next [CHANNELS];
    logic [ACC_BITS-1:0] gap_reg  [CHANNELS];
    logic [ACC_BITS-1:0] gap_next [CHANNELS];
    logic [7:0]          instr_reg  [CHANNELS];
    logic [7:0]          instr_next [CHANNELS];
    logic [7:0]          pitch_mem  [CHANNELS];
    logic [7:0]          pending_reg, pending_next;
    logic [1:0]          remain_reg, remain_next;
    logic                stopped_reg, stopped_next;

    // pitch write port
    logic            pitch_we;
    logic [CH_W-1:0] pitch_idx;
    logic [7:0]      pitch_val;

    // result register
    logic      m_valid_reg;
    note_rec_t res_reg, res_next;
    logic      res_fire;

    // close path
    logic                  close_req;
    logic [CH_W-1:0]       close_idx;
    logic                  close_hit;
    logic                  end_cmd;
    logic [ACC_BITS-1:0]   close_len;
    logic [ACC_BITS-1:0]   close_gap;
    logic [NOTE_ACC_W-1:0] close_len_w;
    logic [NOTE_ACC_W-1:0] close_gap_w;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_FORMAT_VERSION);
    assign prdata    = (paddr[2] == REG_FORMAT_VERSION)
                       ? {{(DATA_W-8){1'b0}}, version_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= VERSION_RESET;
        end else if (cfg_write) begin
            version_reg <= pwdata[7:0];
        end
    end

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_seq_byte;
        end
    end

    // ---------------------------------------------------------------
    // record fields of the channel being closed
    // ---------------------------------------------------------------
    assign close_len = len_reg[close_idx];
    assign close_gap = gap_reg[close_idx];

    if (ACC_BITS >= NOTE_ACC_W) begin : g_acc_trunc
        assign close_len_w = close_len[NOTE_ACC_W-1:0];
        assign close_gap_w = close_gap[NOTE_ACC_W-1:0];
    end else begin : g_acc_ext
        assign close_len_w = {{(NOTE_ACC_W-ACC_BITS){1'b0}}, close_len};
        assign close_gap_w = {{(NOTE_ACC_W-ACC_BITS){1'b0}}, close_gap};
    end

    // ---------------------------------------------------------------
    // byte decode and channel update
    // ---------------------------------------------------------------
    always_comb begin
        logic [3:0]          hi_in;
        logic [3:0]          nib_in;
        logic [3:0]          hi_op;
        logic [3:0]          nib_op;
        logic [ROW_W-1:0]    row_base;
        logic [ROW_W-1:0]    row;
        logic [ACC_BITS:0]   sum;

        hi_in    = byte_reg[7:4];
        nib_in   = byte_reg[3:0];
        hi_op    = pending_reg[7:4];
        nib_op   = pending_reg[3:0];
        row_base = {{(ROW_W-7){1'b0}}, byte_reg[6:0]} + ROW_W'(1);
        row      = ROW_W'(row_base * ROW_TICKS);
        sum      = '0;

        sounding_next = sounding_reg;
        first_next    = first_reg;
        len_next      = len_reg;
        gap_next      = gap_reg;
        instr_next    = instr_reg;
        pending_next  = pending_reg;
        remain_next   = remain_reg;
        stopped_next  = stopped_reg;

        pitch_we  = 1'b0;
        pitch_idx = '0;
        pitch_val = byte_reg;
        close_req = 1'b0;
        close_idx = '0;
        end_cmd   = 1'b0;

        if (advance && !stopped_reg) begin
            if (remain_reg != 2'd0) begin
                // operand byte of a pending command
                remain_next  = remain_reg - 2'd1;
                pending_next = CMD_NONE;
                if (remain_reg != 2'd1) begin
                    // pitch of a three-byte note-on; the trailing byte is dropped
                    if (hi_op == CMD_NOTE_ON && nib_op < 4'(CHANNELS)) begin
                        pitch_we  = 1'b1;
                        pitch_idx = nib_op[CH_W-1:0];
                    end
                end else begin
                    case (hi_op)
                        CMD_NOTE_ON: begin
                            if (nib_op < 4'(CHANNELS)) begin
                                pitch_we  = 1'b1;
                                pitch_idx = nib_op[CH_W-1:0];
                            end
                        end
                        CMD_SAMPLE: begin
                            pitch_we  = 1'b1;
                            pitch_idx = CHAN_WAVE;
                            pitch_val = {1'b0, byte_reg[6:0]};
                        end
                        CMD_INSTR: begin
                            if (nib_op < 4'(CHANNELS)
                                && instr_reg[nib_op[CH_W-1:0]] != byte_reg) begin
                                instr_next[nib_op[CH_W-1:0]] = byte_reg;
                                first_next[nib_op[CH_W-1:0]] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (pitch_we) begin
                    sounding_next[pitch_idx] = 1'b1;
                    len_next[pitch_idx]      = '0;
                end
            end else if (!byte_reg[7]) begin
                // row wait: lengths of sounding channels, gaps of silent ones
                for (int k = 0; k < CHANNELS; k++) begin
                    if (sounding_reg[k]) begin
                        sum = {1'b0, len_reg[k]} + (ACC_BITS+1)'(row);
                        len_next[k] = sum[ACC_BITS] ? ACC_MAX : sum[ACC_BITS-1:0];
                    end else begin
                        sum = {1'b0, gap_reg[k]} + (ACC_BITS+1)'(row);
                        gap_next[k] = sum[ACC_BITS] ? ACC_MAX : sum[ACC_BITS-1:0];
                    end
                end
            end else begin
                case (hi_in)
                    CMD_NOTE_OFF: begin
                        close_req = (nib_in < 4'(CHANNELS));
                        close_idx = nib_in[CH_W-1:0];
                    end
                    CMD_NOTE_ON: begin
                        pending_next = byte_reg;
                        remain_next  = (version_reg == VERSION_SHORT) ? 2'd1 : 2'd2;
                        close_req    = (nib_in < 4'(CHANNELS));
                        close_idx    = nib_in[CH_W-1:0];
                    end
                    CMD_SAMPLE: begin
                        pending_next = byte_reg;
                        remain_next  = 2'd1;
                        close_req    = 1'b1;
                        close_idx    = CHAN_WAVE;
                    end
                    CMD_INSTR: begin
                        pending_next = byte_reg;
                        remain_next  = 2'd1;
                    end
                    CMD_END_E, CMD_END_F: begin
                        close_req    = 1'b1;
                        close_idx    = CHAN_WAVE;
                        end_cmd      = 1'b1;
                        stopped_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end

        // close a sounding channel and emit its record; an end command emits a record too
        close_hit = close_req && sounding_reg[close_idx];
        res_next  = '0;
        if (close_hit) begin
            res_next.has_note   = 1'b1;
            res_next.channel    = close_idx;
            res_next.pitch      = pitch_mem[close_idx];
            res_next.duration   = close_len_w;
            res_next.lead_gap   = close_gap_w;
            res_next.instrument = instr_reg[close_idx];
            res_next.first      = first_reg[close_idx];
            first_next[close_idx]    = 1'b0;
            gap_next[close_idx]      = '0;
            sounding_next[close_idx] = 1'b0;
        end
        res_next.song_end = end_cmd;
        res_fire          = close_hit || end_cmd;
    end

    // ---------------------------------------------------------------
    // state registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sounding_reg <= '0;
            first_reg    <= '1;
            pending_reg  <= CMD_NONE;
            remain_reg   <= 2'd0;
            stopped_reg  <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                len_reg[k]   <= '0;
                gap_reg[k]   <= '0;
                instr_reg[k] <= '0;
            end
        end else begin
            sounding_reg <= sounding_next;
            first_reg    <= first_next;
            pending_reg  <= pending_next;
            remain_reg   <= remain_next;
            stopped_reg  <= stopped_next;
            len_reg      <= len_next;
            gap_reg      <= gap_next;
            instr_reg    <= instr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pitch_we) begin
            pitch_mem[pitch_idx] <= pitch_val;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && res_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_has_note           = res_reg.has_note;
    assign m_note_channel       = res_reg.channel;
    assign m_note_pitch         = res_reg.pitch;
    assign m_note_duration      = res_reg.duration;
    assign m_lead_gap           = res_reg.lead_gap;
    assign m_note_instrument    = res_reg.instrument;
    assign m_first_after_change = res_reg.first;
    assign m_song_end           = res_reg.song_end;

endmodule

`default_nettype wire

// File: sv/msnt_checker.sv
// Port-level checks for the note tracker core, attached by bind.
// Depends on msnt_pkg and music_sequence_note_tracker_core.
`timescale 1ns / 1ps
`default_nettype none

module msnt_checker
    import msnt_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_has_note,
    input wire logic [CH_W-1:0]       m_note_channel,
    input wire logic [7:0]            m_note_pitch,
    input wire logic [NOTE_ACC_W-1:0] m_note_duration,
    input wire logic [NOTE_ACC_W-1:0] m_lead_gap,
    input wire logic                  m_song_end
);

    // a stalled record holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_note_duration)
                                && $stable(m_note_channel) && $stable(m_song_end))
        else $error("result changed while stalled");

    // a record without a note only marks the end of the song
    a_bare_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_note |-> m_song_end)
        else $error("empty result without song end");

    // the end command only closes the wave channel
    a_end_on_wave: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_song_end && m_has_note |-> m_note_channel == CHAN_WAVE)
        else $error("song end closed a channel other than wave");

    // note fields stay clear on a bare end record
    a_bare_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_note |-> m_note_duration == '0 && m_lead_gap == '0
                                   && m_note_pitch == 8'd0)
        else $error("bare end record carries note data");

    // nothing follows the end of the song
    a_quiet_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_song_end |=> !m_valid)
        else $error("result after song end");

endmodule

bind music_sequence_note_tracker_core msnt_checker u_msnt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_has_note     (m_has_note),
    .m_note_channel (m_note_channel),
    .m_note_pitch   (m_note_pitch),
    .m_note_duration(m_note_duration),
    .m_lead_gap     (m_lead_gap),
    .m_song_end     (m_song_end)
);

`default_nettype wire
